/* rtl/core/zps_pkg.sv */
// shared types and constants for the z-buffered pixel store
// no dependencies; used by the store unit and zps_locate by scoped names
`default_nettype none

package zps_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RGBAZ_CLASS  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned DEPTH_W    = 32;

  // pixel count of the active frame, at most 511 * 511
  localparam int unsigned PIX_CNT_W = 2 * DIM_W;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam int unsigned COLOR_W   = 3 * CHAN_W;
  localparam int unsigned ALPHA_Z_W = CHAN_W + DEPTH_W;

  localparam logic signed [CHAN_W-1:0]  CLEAR_ALPHA = 16'sd1;
  localparam logic signed [DEPTH_W-1:0] CLEAR_DEPTH = 32'sd2000000000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_GET   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_CLEAR = 3'b100
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/zbuffered_pixel_store_unit.sv */
// z-buffered frame store: put and get are taken only in idle, where the pixel ram is read;
// in the look state the read data is tested and written, held while the output is full;
// the result is registered into the output register as look returns to idle.
// clear walks the active frame one pixel per ram write.
// reset clears control state, config to 256 x 256 rgbaz; pixel ram is undefined until
// written, and the open flag is clear until the first clear command.
`default_nettype none

module zbuffered_pixel_store_unit #(
  parameter int unsigned MAX_WIDTH   = 256,
  parameter int unsigned MAX_HEIGHT  = 256,
  parameter int unsigned COLOR_SCALE = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [zps_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [zps_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // cmd, x_pos, y_pos, in_red, in_green, in_blue, in_alpha, in_depth, zero pad
  input  wire logic [zps_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // status, out_red, out_green, out_blue, out_alpha, out_depth, zero pad
  output logic      [zps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // data_valid
  output logic                                      m_axis_tuser
);

  localparam int unsigned PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned CW     = zps_pkg::CHAN_W;
  localparam int unsigned ZW     = zps_pkg::DEPTH_W;
  localparam int unsigned DW     = zps_pkg::DIM_W;
  localparam int unsigned NW     = zps_pkg::PIX_CNT_W;

  localparam int CLR_R_RAW = (COLOR_SCALE * 8) / 16;
  localparam int CLR_G_RAW = (COLOR_SCALE * 7) / 16;
  localparam int CLR_B_RAW = (COLOR_SCALE * 6) / 16;
  localparam int COLOR_MAX = COLOR_SCALE - 1;

  localparam logic signed [CW-1:0] CLR_RED   =
    CW'((CLR_R_RAW > COLOR_MAX) ? COLOR_MAX : CLR_R_RAW);
  localparam logic signed [CW-1:0] CLR_GREEN =
    CW'((CLR_G_RAW > COLOR_MAX) ? COLOR_MAX : CLR_G_RAW);
  localparam logic signed [CW-1:0] CLR_BLUE  =
    CW'((CLR_B_RAW > COLOR_MAX) ? COLOR_MAX : CLR_B_RAW);
  localparam logic signed [CW-1:0] COLOR_LIM = CW'(COLOR_MAX);

  function automatic logic signed [CW-1:0] clamp_color(input logic signed [CW-1:0] c);
    clamp_color = (c > COLOR_LIM) ? COLOR_LIM : c;
  endfunction

  // configuration
  logic [DW-1:0] frame_width_q;
  logic [DW-1:0] frame_height_q;
  logic          rgbaz_class_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DW'(256);
      frame_height_q <= DW'(256);
      rgbaz_class_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zps_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        zps_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        zps_pkg::REG_RGBAZ_CLASS:  rgbaz_class_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] act_w;
  logic [DW-1:0] act_h;
  logic [NW-1:0] act_pixels;

  assign act_w = (32'(frame_width_q) > MAX_WIDTH) ? DW'(MAX_WIDTH) : frame_width_q;
  assign act_h = (32'(frame_height_q) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : frame_height_q;
  assign act_pixels = NW'(act_w) * NW'(act_h);

  // input fields
  logic        [1:0]    in_cmd;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic signed [CW-1:0] in_red;
  logic signed [CW-1:0] in_green;
  logic signed [CW-1:0] in_blue;
  logic signed [CW-1:0] in_alpha;
  logic signed [ZW-1:0] in_depth;

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_x     = s_axis_tdata[17:2];
  assign in_y     = s_axis_tdata[33:18];
  assign in_red   = s_axis_tdata[49:34];
  assign in_green = s_axis_tdata[65:50];
  assign in_blue  = s_axis_tdata[81:66];
  assign in_alpha = s_axis_tdata[97:82];
  assign in_depth = s_axis_tdata[129:98];

  logic          loc_in_frame;
  logic [AW-1:0] loc_addr;

  zps_locate #(
    .AW (AW)
  ) u_locate (
    .x_i        (in_x),
    .y_i        (in_y),
    .width_i    (act_w),
    .height_i   (act_h),
    .in_frame_o (loc_in_frame),
    .addr_o     (loc_addr)
  );

  // control and item registers
  zps_pkg::state_e state_q, state_d;
  logic [1:0]           cmd_q;
  logic                 in_frame_q;
  logic [AW-1:0]        addr_q;
  logic [3*CW-1:0]      color_wr_q;
  logic signed [CW-1:0] alpha_wr_q;
  logic signed [ZW-1:0] depth_wr_q;
  logic [NW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [NW-1:0]        clr_num_q;
  logic                 frame_open_q, frame_open_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_status_q, out_status_d;
  logic                  out_dvalid_q, out_dvalid_d;
  logic [4*CW+ZW-1:0]    out_data_q, out_data_d;

  logic in_xfer;
  logic out_free;

  assign s_axis_tready = (state_q == zps_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // pixel rams
  logic                    ram_en;
  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [zps_pkg::COLOR_W-1:0]   color_wdata, color_rdata;
  logic [zps_pkg::ALPHA_Z_W-1:0] az_wdata, az_rdata;

  logic signed [ZW-1:0] stored_depth;
  logic                 is_put, is_get_on, put_wins, clr_busy;

  assign stored_depth = az_rdata[CW +: ZW];
  assign is_put    = (cmd_q == zps_pkg::CMD_PUT);
  assign is_get_on = (cmd_q == zps_pkg::CMD_GET) && rgbaz_class_q;
  // once the frame is open a farther pixel leaves the stored one in place
  assign put_wins  = is_put && in_frame_q && !(frame_open_q && (depth_wr_q > stored_depth));
  assign clr_busy  = (clr_cnt_q != clr_num_q);

  always_comb begin
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = loc_addr;
    color_wdata = {CLR_BLUE, CLR_GREEN, CLR_RED};
    az_wdata    = {zps_pkg::CLEAR_DEPTH, zps_pkg::CLEAR_ALPHA};
    if (state_q == zps_pkg::S_CLEAR && clr_busy) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = AW'(clr_cnt_q);
    end else if (state_q == zps_pkg::S_LOOK && out_free && put_wins) begin
      ram_en      = 1'b1;
      ram_we      = 1'b1;
      ram_addr    = addr_q;
      color_wdata = color_wr_q;
      az_wdata    = {depth_wr_q, alpha_wr_q};
    end else if (in_xfer && loc_in_frame) begin
      ram_en = 1'b1;
    end
  end

  zps_ram #(
    .WIDTH (zps_pkg::COLOR_W),
    .DEPTH (PIXELS)
  ) u_color_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (color_wdata),
    .rdata_o (color_rdata)
  );

  zps_ram #(
    .WIDTH (zps_pkg::ALPHA_Z_W),
    .DEPTH (PIXELS)
  ) u_az_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (az_wdata),
    .rdata_o (az_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    frame_open_d = frame_open_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_dvalid_d = out_dvalid_q;
    out_data_d   = out_data_q;
    unique case (state_q)
      zps_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == zps_pkg::CMD_CLEAR) begin
            state_d      = zps_pkg::S_CLEAR;
            clr_cnt_d    = '0;
            frame_open_d = 1'b1;
          end else begin
            state_d = zps_pkg::S_LOOK;
          end
        end
      end
      zps_pkg::S_LOOK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = (is_put || is_get_on) && !in_frame_q;
          out_dvalid_d = is_get_on && in_frame_q;
          out_data_d   = (is_get_on && in_frame_q) ? {az_rdata, color_rdata} : '0;
          state_d      = zps_pkg::S_IDLE;
        end
      end
      zps_pkg::S_CLEAR: begin
        if (clr_busy) begin
          clr_cnt_d = clr_cnt_q + NW'(1);
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = 1'b0;
          out_dvalid_d = 1'b0;
          out_data_d   = '0;
          state_d      = zps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = zps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= zps_pkg::S_IDLE;
      clr_cnt_q    <= '0;
      frame_open_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      frame_open_q <= frame_open_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_dvalid_q <= out_dvalid_d;
    out_data_q   <= out_data_d;
    if (in_xfer) begin
      cmd_q      <= in_cmd;
      in_frame_q <= loc_in_frame;
      addr_q     <= loc_addr;
      color_wr_q <= {clamp_color(in_blue), clamp_color(in_green), clamp_color(in_red)};
      alpha_wr_q <= in_alpha;
      depth_wr_q <= in_depth;
      clr_num_q  <= act_pixels;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_data_q, out_status_q};
  assign m_axis_tuser  = out_dvalid_q;

  // checks
  a_write_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != zps_pkg::S_IDLE))
    else $error("pixel ram written while idle");

  a_no_write_out_of_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zps_pkg::S_LOOK && !in_frame_q) |-> !ram_we)
    else $error("pixel ram written for an out-of-frame coordinate");

  a_data_means_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dvalid_q) |-> !out_status_q)
    else $error("pixel data returned with failure status");

  a_clear_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zps_pkg::S_CLEAR) |-> (clr_cnt_q <= clr_num_q))
    else $error("clear sweep ran past the active frame");

  a_clear_opens_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_cmd == zps_pkg::CMD_CLEAR) |=> frame_open_q)
    else $error("clear transfer did not open the frame");

endmodule

`default_nettype wire

/* rtl/core/zps_ram.sv */
// generic single-port synchronous ram, one access per cycle, registered read
// no dependencies
`default_nettype none

module zps_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/zps_locate.sv */
// bounds check and linear address for one pixel coordinate
// depends on zps_pkg
`default_nettype none

module zps_locate #(
  parameter int unsigned AW = 16
) (
  input  wire logic signed [zps_pkg::COORD_W-1:0] x_i,
  input  wire logic signed [zps_pkg::COORD_W-1:0] y_i,
  input  wire logic        [zps_pkg::DIM_W-1:0]   width_i,
  input  wire logic        [zps_pkg::DIM_W-1:0]   height_i,
  output logic                                    in_frame_o,
  output logic             [AW-1:0]               addr_o
);

  localparam int unsigned MAG_W = zps_pkg::COORD_W - 1;
  localparam int unsigned PW    = zps_pkg::PIX_CNT_W;

  logic [MAG_W-1:0] x_mag;
  logic [MAG_W-1:0] y_mag;
  logic [PW-1:0]    row_base;
  logic [PW-1:0]    lin_addr;

  assign x_mag = x_i[MAG_W-1:0];
  assign y_mag = y_i[MAG_W-1:0];

  assign in_frame_o = !x_i[MAG_W] && !y_i[MAG_W]
                   && (x_mag < MAG_W'(width_i))
                   && (y_mag < MAG_W'(height_i));

  // in frame both coordinates are below 512, so the low bits carry them
  assign row_base = PW'(y_mag[zps_pkg::DIM_W-1:0]) * PW'(width_i);
  assign lin_addr = row_base + PW'(x_mag[zps_pkg::DIM_W-1:0]);
  assign addr_o   = AW'(lin_addr);

endmodule

`default_nettype wire
